/* rtl/silu_pwl_pkg.sv */
`default_nettype none

package silu_pwl_pkg;

    // Breakpoint table geometry
    localparam int BP_COUNT     = 21;
    localparam int LAST_SEGMENT = 19;
    localparam int BP_IDX_W     = 5;
    localparam int ROM_FRAC     = 16;
    localparam int BP_WIDTH     = 20;

    typedef logic [BP_IDX_W-1:0]        bp_idx_t;
    typedef logic signed [BP_WIDTH-1:0] bp_val_t;

    // SiLU(-5 + 0.5*i), 16 fraction bits, rounded to nearest
    localparam bp_val_t SILU_ROM [BP_COUNT] = '{
        -20'sd2193,   -20'sd3240,   -20'sd4715,   -20'sd6724,   -20'sd9324,
        -20'sd12429,  -20'sd15624,  -20'sd17933,  -20'sd17625,  -20'sd12371,
        20'sd0,       20'sd20397,   20'sd47911,   20'sd80371,   20'sd115448,
        20'sd151411,  20'sd187284,  20'sd222652,  20'sd257429,  20'sd291672,
        20'sd325487
    };

    // Round half up while dropping shamt fraction bits
    function automatic bp_val_t bp_round(input bp_val_t v, input int shamt);
        logic signed [BP_WIDTH:0] biased;
        logic signed [BP_WIDTH:0] half;
        begin
            half   = (shamt > 0) ? ((BP_WIDTH+1)'(1) <<< (shamt - 1)) : '0;
            biased = (BP_WIDTH+1)'(v) + half;
            bp_round = BP_WIDTH'(biased >>> shamt);
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/silu_pwl_rom.sv */
`default_nettype none

module silu_pwl_rom
    import silu_pwl_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)(
    input  wire logic    clk,
    input  wire logic    rd_en,
    input  wire bp_idx_t rd_idx,
    output bp_val_t      rd_lo,
    output bp_val_t      rd_hi
);

    localparam int SHAMT = ROM_FRAC - FRACTION_BITS;

    bp_val_t rd_lo_reg;
    bp_val_t rd_hi_reg;
    bp_idx_t idx_hi;

    // upper breakpoint of the segment; index never exceeds the last segment
    assign idx_hi = rd_idx + bp_idx_t'(1);

    // registered two-port read, rescaled to the working fraction width
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_lo_reg <= bp_round(SILU_ROM[rd_idx], SHAMT);
            rd_hi_reg <= bp_round(SILU_ROM[idx_hi], SHAMT);
        end
    end

    assign rd_lo = rd_lo_reg;
    assign rd_hi = rd_hi_reg;

endmodule

`default_nettype wire

/* rtl/silu_piecewise_linear_lut.sv */
// SiLU by piecewise-linear interpolation over a 21-entry breakpoint ROM.
// Throughput: one word per cycle while the output word is not stalled; the ROM
// read, the multiply and the rounding/select each take one pipeline stage,
// all stalled together.
// Reset (rst_n low, asynchronous) clears the stage valid flags only.
`default_nettype none

module silu_piecewise_linear_lut
    import silu_pwl_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 8
)(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
    input  wire logic                           is_last,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      activation,
    output logic                                last_out
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int CW  = ((SW > F + 4) ? SW : F + 4) + 1;
    localparam int PW  = F + 5;
    localparam int FW  = F + 1;
    localparam int DW  = BP_WIDTH + 1;
    localparam int PRW = FW + 1 + DW;
    localparam int YW  = ((SW > BP_WIDTH + 2) ? SW : BP_WIDTH + 2) + 1;

    localparam logic signed [CW-1:0] LIM  = CW'(5) <<< F;
    localparam logic signed [YW-1:0] SMAX = {{(YW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [YW-1:0] SMIN = ~SMAX;
    localparam logic signed [PRW:0]  HALF = (PRW+1)'(1) <<< (F - 1);

    logic                   adv;

    // stage 0: clamp and segment select
    logic signed [CW-1:0]   x_ext;
    logic signed [CW-1:0]   clamped;
    logic                   is_low;
    logic                   is_high;
    logic [PW-1:0]          pos;
    logic [BP_IDX_W-1:0]    pos_int;
    bp_idx_t                seg_idx;
    logic [FW-1:0]          frac;

    // stage 1 registers
    logic                   valid_s1_reg;
    logic [FW-1:0]          frac_s1_reg;
    logic                   low_s1_reg;
    logic                   high_s1_reg;
    logic signed [SW-1:0]   x_s1_reg;
    logic                   last_s1_reg;
    bp_val_t                y_lo;
    bp_val_t                y_hi;

    // stage 2 registers
    logic signed [DW-1:0]   diff;
    logic signed [PRW-1:0]  prod_next;
    logic                   valid_s2_reg;
    logic signed [PRW-1:0]  prod_s2_reg;
    bp_val_t                y0_s2_reg;
    logic                   low_s2_reg;
    logic                   high_s2_reg;
    logic signed [SW-1:0]   x_s2_reg;
    logic                   last_s2_reg;

    // stage 3
    logic signed [PRW:0]    step_round;
    logic signed [YW-1:0]   y_interp;
    logic signed [YW-1:0]   y_sel;
    logic signed [SW-1:0]   activation_next;
    logic                   out_valid_reg;
    logic signed [SW-1:0]   activation_reg;
    logic                   last_out_reg;

    // whole pipe moves when the output word is free or being taken
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // clamp to [-5, 5], position = 2 * (x + 5)
    always_comb
    begin
        x_ext   = CW'(sample);
        is_low  = (x_ext <= -LIM);
        is_high = (x_ext >= LIM);
        if (is_low)
            clamped = -LIM;
        else if (is_high)
            clamped = LIM;
        else
            clamped = x_ext;
        pos     = PW'(clamped + LIM) << 1;
        pos_int = pos[PW-1:F];
        if (pos_int > BP_IDX_W'(LAST_SEGMENT))
            seg_idx = bp_idx_t'(LAST_SEGMENT);
        else
            seg_idx = pos_int;
        frac    = FW'(pos - (PW'(seg_idx) << F));
    end

    silu_pwl_rom #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_rom (
        .clk    (clk),
        .rd_en  (adv),
        .rd_idx (seg_idx),
        .rd_lo  (y_lo),
        .rd_hi  (y_hi)
    );

    // stage 1 control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_s1_reg <= 1'b0;
        else if (adv)
            valid_s1_reg <= in_valid;
    end

    // stage 1 payload, aligned with the ROM read
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frac_s1_reg <= frac;
            low_s1_reg  <= is_low;
            high_s1_reg <= is_high;
            x_s1_reg    <= sample;
            last_s1_reg <= is_last;
        end
    end

    // slope times fraction
    assign diff      = DW'(y_hi) - DW'(y_lo);
    assign prod_next = $signed({1'b0, frac_s1_reg}) * diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_s2_reg <= 1'b0;
        else if (adv)
            valid_s2_reg <= valid_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_s2_reg <= prod_next;
            y0_s2_reg   <= y_lo;
            low_s2_reg  <= low_s1_reg;
            high_s2_reg <= high_s1_reg;
            x_s2_reg    <= x_s1_reg;
            last_s2_reg <= last_s1_reg;
        end
    end

    // round the step half up, add, pick tails, saturate
    always_comb
    begin
        step_round = ((PRW+1)'(prod_s2_reg) + HALF) >>> F;
        y_interp   = YW'(y0_s2_reg) + YW'(step_round);
        if (low_s2_reg)
            y_sel = '0;
        else if (high_s2_reg)
            y_sel = YW'(x_s2_reg);
        else
            y_sel = y_interp;
        if (y_sel > SMAX)
            activation_next = SW'(SMAX);
        else if (y_sel < SMIN)
            activation_next = SW'(SMIN);
        else
            activation_next = y_sel[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= valid_s2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            activation_reg <= activation_next;
            last_out_reg   <= last_s2_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign activation = activation_reg;
    assign last_out   = last_out_reg;

endmodule

`default_nettype wire

/* rtl/silu_pwl_checker.sv */
`default_nettype none

module silu_pwl_checker #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int FRACTION_BITS = 8
)(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic signed [SAMPLE_WIDTH-1:0] activation,
    input wire logic                           last_out
);

    localparam logic signed [SAMPLE_WIDTH:0] NEG_HALF =
        -((SAMPLE_WIDTH+1)'(1) <<< (FRACTION_BITS - 1));

    // output word held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(activation) && $stable(last_out))
        else $error("output word changed while stalled");

    // an empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with free output");

    // a word accepted into a pipe that keeps moving reaches the output
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 in_ready ##1 in_ready |=> out_valid)
        else $error("accepted word did not reach the output");

    // SiLU never goes below about -0.28; the check uses a floor of -0.5
    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (SAMPLE_WIDTH+1)'(activation) > NEG_HALF)
        else $error("activation below SiLU minimum");

    // no output word while reset is held low across consecutive edges
    a_reset: assert property (@(posedge clk)
        !rst_n ##1 !rst_n |-> !out_valid)
        else $error("output valid during reset");

endmodule

bind silu_piecewise_linear_lut silu_pwl_checker #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_silu_pwl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .activation (activation),
    .last_out   (last_out)
);

`default_nettype wire
